// ----- src/kmp_pkg.sv -----
package kmp_pkg;

    localparam int DEPTH_SLOTS  = 64;
    localparam int LIST_ENTRIES = 256;
    localparam int MOVE_W       = 32;

    localparam int LIST_AW  = $clog2(LIST_ENTRIES);
    localparam int COUNT_W  = $clog2(LIST_ENTRIES + 1);
    localparam int DEPTH_AW = (DEPTH_SLOTS > 1) ? $clog2(DEPTH_SLOTS) : 1;

    typedef struct packed {
        logic signed [MOVE_W-1:0] move;
        logic signed [MOVE_W-1:0] score;
    } entry_t;

    // what a list cell does this cycle
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_FWD  = 2'd1,
        OP_BACK = 2'd2,
        OP_LOAD = 2'd3
    } cell_op_t;

    typedef enum logic [2:0] {
        FN_CLEAR   = 3'd0,
        FN_BEGIN   = 3'd1,
        FN_APPEND  = 3'd2,
        FN_SAVE    = 3'd3,
        FN_PROMOTE = 3'd4,
        FN_READ    = 3'd5
    } func_t;

endpackage

// ----- src/kmp_ram.sv -----
module kmp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/kmp_cell.sv -----
module kmp_cell (
    input  logic              clk,
    input  kmp_pkg::cell_op_t op,
    input  kmp_pkg::entry_t   left_in,
    input  kmp_pkg::entry_t   right_in,
    input  kmp_pkg::entry_t   load_in,
    output kmp_pkg::entry_t   q
);

    kmp_pkg::entry_t data_reg;
    kmp_pkg::entry_t data_next;

    always_comb
    begin
        case (op)
            kmp_pkg::OP_HOLD: data_next = data_reg;
            kmp_pkg::OP_FWD:  data_next = right_in;
            kmp_pkg::OP_BACK: data_next = left_in;
            kmp_pkg::OP_LOAD: data_next = load_in;
            default:          data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ----- src/killer_move_table_and_promoter.sv -----
// killer move table with move list promoter
//
// request channel: start with func, search_depth, list_index, move_in and
// score_in is taken at a rising edge where busy is low. one request at a time;
// busy drops in the cycle the result shows, so the next request can be taken
// at the edge that ends the done cycle.
// result channel: done is high for exactly one cycle with move_out, score_out,
// list_count, found_first, found_second and error_flag. the receiver cannot
// stall; every result is taken in the cycle it shows.
// the move list sits in a ring of cells that rotates one entry per cycle past
// a head cell, so all list access happens at the head. work per request:
//   clear killers, rejected requests: no ring movement
//   begin, append, save, read: seek the entry the shorter way round the ring
//     (ring distance to the entry at most N/2)
//   promote: per pass, seek to start, scan up to the killer or the list end,
//     bubble back to start; N = list entries
// killer slots live in two rams with a valid bit per depth, so clear killers
// and reset take effect at once. reset empties the list and the killers and
// needs no clearing pass; list cells are not reset.
module killer_move_table_and_promoter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          func,
    input  logic [5:0]          search_depth,
    input  logic [7:0]          list_index,
    input  logic signed [31:0]  move_in,
    input  logic signed [31:0]  score_in,
    output logic                done,
    output logic signed [31:0]  move_out,
    output logic signed [31:0]  score_out,
    output logic [8:0]          list_count,
    output logic                found_first,
    output logic                found_second,
    output logic                error_flag
);

    localparam int N   = kmp_pkg::LIST_ENTRIES;
    localparam int LW  = kmp_pkg::LIST_AW;
    localparam int CW  = kmp_pkg::COUNT_W;
    localparam int DA  = kmp_pkg::DEPTH_AW;
    localparam int MW  = kmp_pkg::MOVE_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEEK   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_BUBBLE = 5'b01000,
        ST_SPARE  = 5'b10000
    } state_t;

    // control state
    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [LW-1:0]        rot_reg, rot_next;       // list index held by the head cell
    logic [kmp_pkg::DEPTH_SLOTS-1:0] kvalid_reg, kvalid_next;
    logic                 done_reg, done_next;

    // request and work registers
    kmp_pkg::func_t       func_reg, func_next;
    logic [DA-1:0]        depth_reg, depth_next;
    logic [LW-1:0]        target_reg, target_next; // seek target, also pass start
    logic [CW-1:0]        scan_ix_reg, scan_ix_next;
    logic [MW-1:0]        key_reg, key_next;
    logic                 pass_reg, pass_next;
    logic                 f1_reg, f1_next;
    logic                 kv_reg, kv_next;
    kmp_pkg::entry_t      load_reg, load_next;

    // result registers
    logic signed [MW-1:0] mo_reg, mo_next;
    logic signed [MW-1:0] so_reg, so_next;
    logic [CW-1:0]        cnt_out_reg, cnt_out_next;
    logic                 fo1_reg, fo1_next;
    logic                 fo2_reg, fo2_next;
    logic                 err_reg, err_next;

    // ring control
    kmp_pkg::cell_op_t    ring_op, head_op;
    logic                 swap;
    kmp_pkg::entry_t      cell_q [N];
    kmp_pkg::entry_t      head;

    // killer rams
    logic                 kre, kwe;
    logic [MW-1:0]        rd_first, rd_second;
    logic [MW-1:0]        first_eff, second_eff;

    // sequencing helpers
    logic                 fin, fin_err, fin_f1, fin_f2;
    logic signed [MW-1:0] fin_mo, fin_so;
    logic                 pass_done, pass_found;
    logic [LW:0]          fwd_dist;
    logic [CW-1:0]        start2;
    logic [LW-1:0]        rot_inc, rot_dec;
    logic                 depth_bad, idx_bad;

    assign head       = cell_q[0];
    assign first_eff  = kv_reg ? rd_first : '0;
    assign second_eff = kv_reg ? rd_second : '0;
    assign rot_inc    = (rot_reg == LW'(N - 1)) ? '0 : rot_reg + LW'(1);
    assign rot_dec    = (rot_reg == '0) ? LW'(N - 1) : rot_reg - LW'(1);
    assign depth_bad  = 9'(search_depth) >= 9'(kmp_pkg::DEPTH_SLOTS);
    assign idx_bad    = {1'b0, list_index} >= 9'(count_reg);
    assign start2     = CW'(target_reg) + CW'(1);

    // forward ring distance from the head to the target
    always_comb
    begin
        if (target_reg >= rot_reg)
        begin
            fwd_dist = (LW+1)'(target_reg) - (LW+1)'(rot_reg);
        end
        else
        begin
            fwd_dist = (LW+1)'(target_reg) + (LW+1)'(N) - (LW+1)'(rot_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rot_next     = rot_reg;
        kvalid_next  = kvalid_reg;
        done_next    = 1'b0;
        func_next    = func_reg;
        depth_next   = depth_reg;
        target_next  = target_reg;
        scan_ix_next = scan_ix_reg;
        key_next     = key_reg;
        pass_next    = pass_reg;
        f1_next      = f1_reg;
        kv_next      = kv_reg;
        load_next    = load_reg;
        mo_next      = mo_reg;
        so_next      = so_reg;
        cnt_out_next = cnt_out_reg;
        fo1_next     = fo1_reg;
        fo2_next     = fo2_reg;
        err_next     = err_reg;
        ring_op      = kmp_pkg::OP_HOLD;
        head_op      = kmp_pkg::OP_HOLD;
        swap         = 1'b0;
        kre          = 1'b0;
        kwe          = 1'b0;
        fin          = 1'b0;
        fin_err      = 1'b0;
        fin_f1       = 1'b0;
        fin_f2       = 1'b0;
        fin_mo       = '0;
        fin_so       = '0;
        pass_done    = 1'b0;
        pass_found   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next   = kmp_pkg::func_t'(func);
                    depth_next  = DA'(search_depth);
                    load_next   = '{move: move_in, score: score_in};
                    target_next = LW'(list_index);
                    pass_next   = 1'b0;
                    f1_next     = 1'b0;
                    kv_next     = kvalid_reg[DA'(search_depth)];
                    case (kmp_pkg::func_t'(func))
                        kmp_pkg::FN_CLEAR:
                        begin
                            kvalid_next = '0;
                            fin         = 1'b1;
                        end
                        kmp_pkg::FN_BEGIN:
                        begin
                            target_next = '0;
                            state_next  = ST_SEEK;
                        end
                        kmp_pkg::FN_APPEND:
                        begin
                            if (count_reg >= CW'(N))
                            begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end
                            else
                            begin
                                target_next = LW'(count_reg);
                                state_next  = ST_SEEK;
                            end
                        end
                        kmp_pkg::FN_SAVE, kmp_pkg::FN_PROMOTE:
                        begin
                            if (depth_bad || idx_bad)
                            begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end
                            else
                            begin
                                kre        = 1'b1;
                                state_next = ST_SEEK;
                            end
                        end
                        kmp_pkg::FN_READ:
                        begin
                            if (idx_bad)
                            begin
                                fin     = 1'b1;
                                fin_err = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SEEK;
                            end
                        end
                        default:
                        begin
                            fin     = 1'b1;
                            fin_err = 1'b1;
                        end
                    endcase
                end
            end

            ST_SEEK:
            begin
                if (rot_reg == target_reg)
                begin
                    case (func_reg)
                        kmp_pkg::FN_BEGIN:
                        begin
                            head_op    = kmp_pkg::OP_LOAD;
                            count_next = CW'(1);
                            fin        = 1'b1;
                        end
                        kmp_pkg::FN_APPEND:
                        begin
                            head_op    = kmp_pkg::OP_LOAD;
                            count_next = count_reg + CW'(1);
                            fin        = 1'b1;
                        end
                        kmp_pkg::FN_SAVE:
                        begin
                            // same move in slot one leaves both slots alone
                            if (first_eff != head.move)
                            begin
                                kwe                    = 1'b1;
                                kvalid_next[depth_reg] = 1'b1;
                            end
                            fin = 1'b1;
                        end
                        kmp_pkg::FN_READ:
                        begin
                            fin_mo = head.move;
                            fin_so = head.score;
                            fin    = 1'b1;
                        end
                        kmp_pkg::FN_PROMOTE:
                        begin
                            scan_ix_next = CW'(target_reg);
                            key_next     = pass_reg ? second_eff : first_eff;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                            fin     = 1'b1;
                            fin_err = 1'b1;
                        end
                    endcase
                end
                else if (fwd_dist <= (LW+1)'(N / 2))
                begin
                    ring_op  = kmp_pkg::OP_FWD;
                    head_op  = kmp_pkg::OP_FWD;
                    rot_next = rot_inc;
                end
                else
                begin
                    ring_op  = kmp_pkg::OP_BACK;
                    head_op  = kmp_pkg::OP_BACK;
                    rot_next = rot_dec;
                end
            end

            ST_SCAN:
            begin
                // bound is tested before the entry is compared
                if (scan_ix_reg >= count_reg)
                begin
                    pass_done = 1'b1;
                end
                else if (head.move == key_reg)
                begin
                    if (rot_reg == target_reg)
                    begin
                        pass_done  = 1'b1;
                        pass_found = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_BUBBLE;
                    end
                end
                else
                begin
                    ring_op      = kmp_pkg::OP_FWD;
                    head_op      = kmp_pkg::OP_FWD;
                    rot_next     = rot_inc;
                    scan_ix_next = scan_ix_reg + CW'(1);
                end
            end

            ST_BUBBLE:
            begin
                if (rot_reg == target_reg)
                begin
                    pass_done  = 1'b1;
                    pass_found = 1'b1;
                end
                else
                begin
                    // head keeps the killer, the entry below it passes to cell one
                    ring_op  = kmp_pkg::OP_BACK;
                    head_op  = kmp_pkg::OP_HOLD;
                    swap     = 1'b1;
                    rot_next = rot_dec;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pass_done)
        begin
            if (!pass_reg)
            begin
                f1_next   = pass_found;
                pass_next = 1'b1;
                // second pass starting at the list end finds nothing
                if (start2 >= count_reg)
                begin
                    fin    = 1'b1;
                    fin_f1 = pass_found;
                end
                else
                begin
                    target_next = LW'(start2);
                    state_next  = ST_SEEK;
                end
            end
            else
            begin
                fin    = 1'b1;
                fin_f1 = f1_reg;
                fin_f2 = pass_found;
            end
        end

        if (fin)
        begin
            state_next   = ST_IDLE;
            done_next    = 1'b1;
            mo_next      = fin_mo;
            so_next      = fin_so;
            cnt_out_next = count_next;
            fo1_next     = fin_f1;
            fo2_next     = fin_f2;
            err_next     = fin_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rot_reg    <= '0;
            kvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rot_reg    <= rot_next;
            kvalid_reg <= kvalid_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        depth_reg   <= depth_next;
        target_reg  <= target_next;
        scan_ix_reg <= scan_ix_next;
        key_reg     <= key_next;
        pass_reg    <= pass_next;
        f1_reg      <= f1_next;
        kv_reg      <= kv_next;
        load_reg    <= load_next;
        mo_reg      <= mo_next;
        so_reg      <= so_next;
        cnt_out_reg <= cnt_out_next;
        fo1_reg     <= fo1_next;
        fo2_reg     <= fo2_next;
        err_reg     <= err_next;
    end

    // killer slots: slot two takes the old slot one on every write
    kmp_ram #(
        .WIDTH (MW),
        .DEPTH (kmp_pkg::DEPTH_SLOTS)
    ) u_first_ram (
        .clk   (clk),
        .we    (kwe),
        .waddr (depth_reg),
        .wdata (head.move),
        .re    (kre),
        .raddr (DA'(search_depth)),
        .rdata (rd_first)
    );

    kmp_ram #(
        .WIDTH (MW),
        .DEPTH (kmp_pkg::DEPTH_SLOTS)
    ) u_second_ram (
        .clk   (clk),
        .we    (kwe),
        .waddr (depth_reg),
        .wdata (first_eff),
        .re    (kre),
        .raddr (DA'(search_depth)),
        .rdata (rd_second)
    );

    // ring of list cells, cell zero is the head
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        kmp_pkg::entry_t left_in;
        kmp_pkg::entry_t right_in;

        if (k == 0)
        begin : g_head
            assign left_in = cell_q[N-1];
        end
        else if (k == 1)
        begin : g_after_head
            assign left_in = swap ? cell_q[N-1] : cell_q[0];
        end
        else
        begin : g_body
            assign left_in = cell_q[k-1];
        end

        assign right_in = cell_q[(k + 1) % N];

        kmp_cell u_cell (
            .clk      (clk),
            .op       ((k == 0) ? head_op : ring_op),
            .left_in  (left_in),
            .right_in (right_in),
            .load_in  (load_reg),
            .q        (cell_q[k])
        );
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign move_out     = mo_reg;
    assign score_out    = so_reg;
    assign list_count   = 9'(cnt_out_reg);
    assign found_first  = fo1_reg;
    assign found_second = fo2_reg;
    assign error_flag   = err_reg;

    // a result follows only a request or work in progress
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result without a request");

    // a rejected request reports no killer found
    a_err_no_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_flag) |-> (!found_first && !found_second))
        else $error("found flag on a rejected request");

    // bubbling never moves the killer below the pass start
    a_bubble_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUBBLE) |-> (rot_reg >= target_reg))
        else $error("bubble ran past the pass start");

    // the list never holds more entries than cells
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("list count above capacity");

endmodule

// ----- sim/tb_killer_move_table_and_promoter.sv -----
`timescale 1ns / 100ps

module tb_killer_move_table_and_promoter;

    // func codes the block rejects
    localparam logic [2:0] FN_BAD_LO = 3'd6;
    localparam logic [2:0] FN_BAD_HI = 3'd7;

    localparam int ITEMS       = 850;
    // promote on a full list is the slowest request
    localparam int LATENCY_MAX = 5 * kmp_pkg::LIST_ENTRIES + 64;

    // one result as seen on the output ports
    typedef struct packed {
        logic [31:0] move;
        logic [31:0] score;
        logic [8:0]  count;
        logic        hit_first;
        logic        hit_second;
        logic        err;
    } outcome_t;

    // killer table and move list as the block should hold them, plus the
    // results still owed by the block in request order
    class killer_scoreboard;
        logic [31:0] first_slot  [kmp_pkg::DEPTH_SLOTS];
        logic [31:0] second_slot [kmp_pkg::DEPTH_SLOTS];
        logic [31:0] moves       [kmp_pkg::LIST_ENTRIES];
        logic [31:0] scores      [kmp_pkg::LIST_ENTRIES];
        int unsigned fill;
        int unsigned peak_fill;
        outcome_t    expected_q [$];
        int          n_bad;
        int          n_seen;
        int          n_errs;
        int          n_hit_first;
        int          n_hit_second;

        function new();
            for (int d = 0; d < kmp_pkg::DEPTH_SLOTS; d++)
            begin
                first_slot[d]  = '0;
                second_slot[d] = '0;
            end
            for (int e = 0; e < kmp_pkg::LIST_ENTRIES; e++)
            begin
                moves[e]  = '0;
                scores[e] = '0;
            end
            fill = 0;
            peak_fill = 0;
            n_bad = 0;
            n_seen = 0;
            n_errs = 0;
            n_hit_first = 0;
            n_hit_second = 0;
        endfunction

        // search from pos for key, bound tested before each compare;
        // a hit is lifted to pos and the entries in between move down one
        function bit lift_entry(int unsigned pos, logic [31:0] key);
            int unsigned j;
            int unsigned i;
            logic [31:0] m;
            logic [31:0] s;
            j = pos;
            while (j < fill && moves[j] != key)
                j++;
            if (j >= fill)
                return 1'b0;
            m = moves[j];
            s = scores[j];
            for (i = j; i > pos; i--)
            begin
                moves[i]  = moves[i-1];
                scores[i] = scores[i-1];
            end
            moves[pos]  = m;
            scores[pos] = s;
            return 1'b1;
        endfunction

        // work out the result of an accepted request and queue it
        function void note_request(logic [2:0] fn, logic [5:0] depth, logic [7:0] idx,
                                   logic [31:0] mv, logic [31:0] sc);
            outcome_t r;
            r = '0;
            case (fn)
                kmp_pkg::FN_CLEAR:
                begin
                    for (int d = 0; d < kmp_pkg::DEPTH_SLOTS; d++)
                    begin
                        first_slot[d]  = '0;
                        second_slot[d] = '0;
                    end
                end
                kmp_pkg::FN_BEGIN:
                begin
                    moves[0]  = mv;
                    scores[0] = sc;
                    fill = 1;
                end
                kmp_pkg::FN_APPEND:
                begin
                    if (fill >= kmp_pkg::LIST_ENTRIES)
                        r.err = 1'b1;
                    else
                    begin
                        moves[fill]  = mv;
                        scores[fill] = sc;
                        fill++;
                    end
                end
                kmp_pkg::FN_SAVE:
                begin
                    if (depth >= kmp_pkg::DEPTH_SLOTS || idx >= fill)
                        r.err = 1'b1;
                    else if (first_slot[depth] != moves[idx])
                    begin
                        second_slot[depth] = first_slot[depth];
                        first_slot[depth]  = moves[idx];
                    end
                end
                kmp_pkg::FN_PROMOTE:
                begin
                    if (depth >= kmp_pkg::DEPTH_SLOTS || idx >= fill)
                        r.err = 1'b1;
                    else
                    begin
                        r.hit_first  = lift_entry(idx, first_slot[depth]);
                        r.hit_second = lift_entry(idx + 1, second_slot[depth]);
                    end
                end
                kmp_pkg::FN_READ:
                begin
                    if (idx >= fill)
                        r.err = 1'b1;
                    else
                    begin
                        r.move  = moves[idx];
                        r.score = scores[idx];
                    end
                end
                default:
                    r.err = 1'b1;
            endcase
            r.count = 9'(fill);
            if (fill > peak_fill)
                peak_fill = fill;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            n_bad++;
            $display("%0t ns  mismatch: %s", $time, msg);
        endtask

        // compare one result with the oldest one owed
        task check_result(outcome_t got);
            outcome_t want;
            n_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                          n_seen));
                return;
            end
            want = expected_q.pop_front();
            if (got.move !== want.move)
                report_mismatch($sformatf("result %0d move_out %h, want %h",
                                          n_seen, got.move, want.move));
            if (got.score !== want.score)
                report_mismatch($sformatf("result %0d score_out %h, want %h",
                                          n_seen, got.score, want.score));
            if (got.count !== want.count)
                report_mismatch($sformatf("result %0d list_count %0d, want %0d",
                                          n_seen, got.count, want.count));
            if (got.hit_first !== want.hit_first)
                report_mismatch($sformatf("result %0d found_first %b, want %b",
                                          n_seen, got.hit_first, want.hit_first));
            if (got.hit_second !== want.hit_second)
                report_mismatch($sformatf("result %0d found_second %b, want %b",
                                          n_seen, got.hit_second, want.hit_second));
            if (got.err !== want.err)
                report_mismatch($sformatf("result %0d error_flag %b, want %b",
                                          n_seen, got.err, want.err));
            if (want.err)
                n_errs++;
            if (want.hit_first)
                n_hit_first++;
            if (want.hit_second)
                n_hit_second++;
        endtask
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               start        = 1'b0;
    logic [2:0]         func         = '0;
    logic [5:0]         search_depth = '0;
    logic [7:0]         list_index   = '0;
    logic signed [31:0] move_in      = '0;
    logic signed [31:0] score_in     = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] move_out;
    logic signed [31:0] score_out;
    logic [8:0]         list_count;
    logic               found_first;
    logic               found_second;
    logic               error_flag;

    killer_scoreboard sb = new();

    int n_sent  = 0;

    always #4 clk = ~clk;

    killer_move_table_and_promoter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .search_depth (search_depth),
        .list_index   (list_index),
        .move_in      (move_in),
        .score_in     (score_in),
        .done         (done),
        .move_out     (move_out),
        .score_out    (score_out),
        .list_count   (list_count),
        .found_first  (found_first),
        .found_second (found_second),
        .error_flag   (error_flag)
    );

    // result side: done marks the single cycle a result is valid
    always @(posedge clk)
    begin
        outcome_t got;
        if (rst_n && done)
        begin
            got.move       = move_out;
            got.score      = score_out;
            got.count      = list_count;
            got.hit_first  = found_first;
            got.hit_second = found_second;
            got.err        = error_flag;
            sb.check_result(got);
        end
    end

    // present one request, hold it until the block takes it, then predict it;
    // start only drops when a gap follows, so back to back requests keep it high
    task send_request(input logic [2:0] fn, input logic [5:0] depth, input logic [7:0] idx,
                      input logic [31:0] mv, input logic [31:0] sc);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        func         <= fn;
        search_depth <= depth;
        list_index   <= idx;
        move_in      <= mv;
        score_in     <= sc;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(fn, depth, idx, mv, sc);
        n_sent++;
    endtask

    // stop sending and wait until every owed result is back
    task drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // half the moves come from a small pool so killers hit list entries
    function automatic logic [31:0] pick_move();
        logic [31:0] pool [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h0000_0101, 32'h0000_0c2a, 32'h0001_0304, 32'h0000_0e4d};
        if ($urandom_range(0, 1))
            return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // a few hot depths so saves and promotes meet, any depth now and then
    function automatic logic [5:0] pick_depth();
        if ($urandom_range(0, 9) < 7)
            return 6'($urandom_range(0, 3));
        return 6'($urandom);
    endfunction

    initial
    begin
        int          kind;
        int          size;
        int          pick;
        logic [5:0]  depth;
        logic [7:0]  at;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty list rejects, field extremes, killer save and
        // both promote passes, second pass past the end, bad codes
        send_request(kmp_pkg::FN_READ,    6'd0,  8'd0,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_SAVE,    6'd0,  8'd0,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_PROMOTE, 6'd0,  8'd0,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_APPEND,  6'd0,  8'd0,   32'h8000_0000, 32'h7fff_ffff);
        send_request(kmp_pkg::FN_BEGIN,   6'd63, 8'd255, 32'h7fff_ffff, 32'h8000_0000);
        send_request(kmp_pkg::FN_APPEND,  6'd0,  8'd0,   32'hffff_ffff, 32'h0);
        send_request(kmp_pkg::FN_APPEND,  6'd0,  8'd0,   32'h0, 32'hffff_ffff);
        send_request(kmp_pkg::FN_APPEND,  6'd0,  8'd0,   32'h1234_5678, 32'h5);
        send_request(kmp_pkg::FN_APPEND,  6'd0,  8'd0,   32'hffff_ffff, 32'h1);
        // same move twice leaves the slot pair alone the second time
        send_request(kmp_pkg::FN_SAVE,    6'd63, 8'd3,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_SAVE,    6'd63, 8'd3,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_SAVE,    6'd63, 8'd1,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_PROMOTE, 6'd63, 8'd0,   32'h0, 32'h0);
        // start on the last entry: second pass starts past the end
        send_request(kmp_pkg::FN_PROMOTE, 6'd63, 8'd4,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_PROMOTE, 6'd63, 8'd5,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_SAVE,    6'd5,  8'd255, 32'h0, 32'h0);
        send_request(kmp_pkg::FN_READ,    6'd0,  8'd0,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_READ,    6'd0,  8'd1,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_READ,    6'd0,  8'd4,   32'h0, 32'h0);
        send_request(FN_BAD_LO,           6'd63, 8'd0,   32'hffff_ffff, 32'hffff_ffff);
        send_request(FN_BAD_HI,           6'd0,  8'd255, 32'h0, 32'h0);
        // clear killers leaves the list; zero killers then match a zero move
        send_request(kmp_pkg::FN_CLEAR,   6'd42, 8'd17,  32'hdead_beef, 32'h1);
        send_request(kmp_pkg::FN_PROMOTE, 6'd63, 8'd0,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_READ,    6'd0,  8'd255, 32'h0, 32'h0);

        // fill the list to capacity, overflow it, work at the far end
        send_request(kmp_pkg::FN_BEGIN, 6'($urandom), 8'($urandom), pick_move(), $urandom);
        while (sb.fill < kmp_pkg::LIST_ENTRIES)
        begin
            send_request(kmp_pkg::FN_APPEND, 6'($urandom), 8'($urandom), pick_move(),
                         $urandom);
        end
        send_request(kmp_pkg::FN_APPEND,  6'd0, 8'd0,   $urandom, $urandom);
        send_request(kmp_pkg::FN_SAVE,    6'd7, 8'd255, 32'h0, 32'h0);
        send_request(kmp_pkg::FN_SAVE,    6'd7, 8'd200, 32'h0, 32'h0);
        send_request(kmp_pkg::FN_PROMOTE, 6'd7, 8'd0,   32'h0, 32'h0);
        send_request(kmp_pkg::FN_PROMOTE, 6'd7, 8'd254, 32'h0, 32'h0);
        send_request(kmp_pkg::FN_PROMOTE, 6'd7, 8'd255, 32'h0, 32'h0);
        send_request(kmp_pkg::FN_READ,    6'd0, 8'd255, 32'h0, 32'h0);
        send_request(kmp_pkg::FN_READ,    6'd0, 8'd0,   32'h0, 32'h0);
        // hold off until the block has caught up completely
        drain_results();

        // random rounds: mostly well-formed list builds with saves, promotes
        // and reads, plus noise and requests against a stale list
        while (n_sent < ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_request(3'($urandom), 6'($urandom), 8'($urandom), $urandom, $urandom);
            end
            else if (kind == 1)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    at = 8'(sb.fill + $urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: send_request(kmp_pkg::FN_APPEND, pick_depth(), 8'($urandom),
                                        pick_move(), $urandom);
                        1: send_request(kmp_pkg::FN_SAVE, pick_depth(), at, $urandom, $urandom);
                        2: send_request(kmp_pkg::FN_PROMOTE, pick_depth(), at, $urandom,
                                        $urandom);
                        default: send_request(kmp_pkg::FN_READ, 6'($urandom), at, $urandom,
                                              $urandom);
                    endcase
                end
            end
            else
            begin
                size  = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 64)
                                                     : $urandom_range(1, 10);
                depth = pick_depth();
                if ($urandom_range(0, 11) == 0)
                    send_request(kmp_pkg::FN_CLEAR, 6'($urandom), 8'($urandom), $urandom,
                                 $urandom);
                send_request(kmp_pkg::FN_BEGIN, 6'($urandom), 8'($urandom), pick_move(),
                             $urandom);
                repeat (size - 1)
                    send_request(kmp_pkg::FN_APPEND, 6'($urandom), 8'($urandom), pick_move(),
                                 $urandom);
                repeat ($urandom_range(1, 3))
                    send_request(kmp_pkg::FN_SAVE, depth, 8'($urandom_range(0, sb.fill - 1)),
                                 $urandom, $urandom);
                repeat ($urandom_range(1, 2))
                begin
                    pick = $urandom_range(0, 3);
                    if (pick == 0)
                        at = 8'd0;
                    else if (pick == 1)
                        at = 8'(sb.fill - 1);
                    else
                        at = 8'($urandom_range(0, sb.fill - 1));
                    send_request(kmp_pkg::FN_PROMOTE, depth, at, $urandom, $urandom);
                end
                repeat ($urandom_range(1, 3))
                    send_request(kmp_pkg::FN_READ, 6'($urandom),
                                 8'($urandom_range(0, sb.fill - 1)), $urandom, $urandom);
            end
            if ($urandom_range(0, 40) == 0)
                drain_results();
        end

        // let everything owed come back, then watch for stray results
        drain_results();
        repeat (LATENCY_MAX) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d of them rejected",
                 n_sent, sb.n_seen, sb.n_errs);
        $display("list peak %0d, first killer lifted %0d times, second %0d times, %0d mismatches",
                 sb.peak_fill, sb.n_hit_first, sb.n_hit_second, sb.n_bad);
        if (sb.n_bad == 0 && sb.expected_q.size() == 0)
            $display("killer_move_table_and_promoter regression: pass");
        else
            $display("killer_move_table_and_promoter regression: fail");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("timeout waiting on the block");
        $display("killer_move_table_and_promoter regression: fail");
        $finish;
    end

endmodule
